>>> rtl/fdl_pkg.sv
// Shared types and constants of the feedback delay line.
package fdl_pkg;

    localparam int DELAY_W    = 25;
    localparam int FB_W       = 16;
    localparam int WET_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int GAIN_FRAC  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET      = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET  = 25'd6144000;
    localparam logic [FB_W-1:0]    FEEDBACK_MAX = 16'd62259;
    localparam logic [WET_W-1:0]   WET_ONE      = 17'd65536;
    localparam logic [WET_W-1:0]   BYPASS_LIMIT = 17'd65;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_RD1,
        ST_RD2,
        ST_DIFF,
        ST_MULI,
        ST_SUMI,
        ST_MULF,
        ST_WRITE,
        ST_DONE
    } fdl_state_t;

    typedef enum logic [1:0] {
        WRAP_IDLE,
        WRAP_QUOT,
        WRAP_REM
    } wrap_step_t;

endpackage

>>> rtl/fdl_delay_wrap.sv
// Delay reduction: delay modulo the store length in fractional units, by reciprocal multiply.
module fdl_delay_wrap
    import fdl_pkg::*;
#(
    parameter int DEPTH     = 131072,
    parameter int FRAC_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [DELAY_W-1:0]                    value,
    output logic                                  busy,
    output logic [$clog2(DEPTH)+FRAC_BITS-1:0]    rem
);

    localparam int     AW      = $clog2(DEPTH);
    localparam int     ROUT_W  = AW + FRAC_BITS;
    localparam int     EXT_W   = (ROUT_W > DELAY_W) ? ROUT_W : DELAY_W;
    localparam int     SHIFT   = DELAY_W + ROUT_W;
    localparam int     RECIP_W = DELAY_W + 2;
    localparam int     PROD_W  = DELAY_W + RECIP_W;
    localparam longint TOTAL   = longint'(DEPTH) << FRAC_BITS;
    // ceil(2^SHIFT / TOTAL) gives the exact quotient for every delay value
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << SHIFT) + TOTAL - 1) / TOTAL);
    localparam logic [DELAY_W-1:0] TOTAL_LOW = DELAY_W'(TOTAL);

    wrap_step_t         step_reg, step_next;
    logic [DELAY_W-1:0] value_reg;
    logic [DELAY_W-1:0] quot_reg;
    logic [DELAY_W-1:0] rem_reg;
    logic [PROD_W-1:0]  prod;
    logic [EXT_W-1:0]   rem_ext;

    assign prod    = PROD_W'(value_reg) * PROD_W'(RECIP);
    assign rem_ext = EXT_W'(rem_reg);
    assign rem     = rem_ext[ROUT_W-1:0];
    assign busy    = (step_reg != WRAP_IDLE);

    always_comb begin
        case (step_reg)
            WRAP_QUOT: step_next = WRAP_REM;
            WRAP_REM:  step_next = WRAP_IDLE;
            default:   step_next = WRAP_IDLE;
        endcase
        // restart on a new delay value
        if (start) begin
            step_next = WRAP_QUOT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= WRAP_QUOT;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= DELAY_RESET;
        end else if (start) begin
            value_reg <= value;
        end
    end

    // Quotient first, then subtract its multiple of the store length
    always_ff @(posedge aclk) begin
        if (step_reg == WRAP_QUOT) begin
            quot_reg <= DELAY_W'(prod >> SHIFT);
        end
        if (step_reg == WRAP_REM) begin
            rem_reg <= value_reg - quot_reg * TOTAL_LOW;
        end
    end

endmodule

>>> rtl/feedback_delay_line_unit.sv
// Feedback echo with fractional delay, linear interpolation and a shared multiplier.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: sample_in
//  m_        out  m_tvalid/m_tready  m_tdata: sample_out
//  cfg_      in   cfg_we             cfg_index, cfg_data (delay_q8, feedback_gain, wet_gain)
//
// An echo item passes through these steps between one accept and the next: the idle cycle that takes it,
// address, two reads of the single-port store, difference, interpolation product and sum,
// feedback product, wet product beside the store write, and the output load.
// A bypass item goes from the idle state straight to the output load. An item is taken only
// in the idle state. After reset and after each delay write, input is held off while the
// delay is reduced modulo the store length. The store is not cleared: entries not yet
// written since reset read as zero through the fill tracking of the write pointer.
// A waiting result holds in the output register; the next item may already be accepted.
module feedback_delay_line_unit
    import fdl_pkg::*;
#(
    parameter int BUFFER_DEPTH    = 131072,
    parameter int SAMPLE_BITS     = 16,
    parameter int DELAY_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    input  logic                                cfg_we,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data
);

    localparam int S       = SAMPLE_BITS;
    localparam int F       = DELAY_FRAC_BITS;
    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int ROUT_W  = AW + F;
    localparam int POS_W   = ROUT_W + 1;
    localparam int FRAC_W  = (F > 0) ? F : 1;
    localparam int DIFF_W  = S + 1;
    localparam int PW      = DIFF_W + WET_W + 1;
    localparam int SUMW    = S + 2;
    localparam int TDATA_W = ((S + 7) / 8) * 8;

    localparam logic [POS_W-1:0]       TOTAL     = POS_W'(BUFFER_DEPTH) << F;
    localparam logic [AW-1:0]          LAST_IDX  = AW'(BUFFER_DEPTH - 1);
    localparam logic [FRAC_W-1:0]      FRAC_MASK = FRAC_W'((64'd1 << F) - 64'd1);
    localparam logic signed [PW-1:0]   ROUND_C   = PW'(1) << (GAIN_FRAC - 1);
    localparam logic signed [SUMW-1:0] SAT_HI    = {3'b000, {(S-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_LO    = {3'b111, {(S-1){1'b0}}};

    fdl_state_t state_reg, state_next;

    logic [FB_W-1:0]          fb_reg;
    logic [WET_W-1:0]         wet_reg;
    logic [AW-1:0]            wp_reg;
    logic                     full_reg;
    logic signed [S-1:0]      x_reg;
    logic                     bypass_reg;
    logic [AW-1:0]            i1_reg, i2_reg;
    logic [FRAC_W-1:0]        frac_reg;
    logic                     v1_reg, v2_reg;
    logic signed [S-1:0]      s1_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [S-1:0]      delayed_reg;
    logic signed [PW-1:0]     prod_reg;
    logic                     m_tvalid_reg;
    logic [S-1:0]             m_tdata_reg;

    logic [S-1:0]             store [BUFFER_DEPTH];
    logic [S-1:0]             rd_data_reg;
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;

    logic                     rem_busy;
    logic [ROUT_W-1:0]        delay_rem;
    logic                     delay_start;

    logic [POS_W-1:0]         pos_sum, pos;
    logic [AW-1:0]            i1, i2;
    logic signed [DIFF_W-1:0] mul_a;
    logic [WET_W-1:0]         mul_b;
    logic signed [PW-1:0]     prod_next;
    logic signed [PW-1:0]     scaled_full;
    logic signed [SUMW-1:0]   mix_sum;
    logic signed [S-1:0]      mix_sat;
    logic signed [S-1:0]      s2;
    logic                     accept, load_out;

    fdl_delay_wrap #(
        .DEPTH     (BUFFER_DEPTH),
        .FRAC_BITS (DELAY_FRAC_BITS)
    ) u_wrap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (delay_start),
        .value   (cfg_data[DELAY_W-1:0]),
        .busy    (rem_busy),
        .rem     (delay_rem)
    );

    assign delay_start = cfg_we && (cfg_index == REG_DELAY);

    // Configuration: clamp gains on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_reg  <= '0;
            wet_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FEEDBACK: fb_reg  <= (cfg_data[FB_W-1:0] > FEEDBACK_MAX) ?
                                         FEEDBACK_MAX : cfg_data[FB_W-1:0];
                REG_WET:      wet_reg <= (cfg_data[WET_W-1:0] > WET_ONE) ?
                                         WET_ONE : cfg_data[WET_W-1:0];
                default: ;
            endcase
        end
    end

    // Read position: write pointer minus delay, wrapped over the store
    assign pos_sum = (POS_W'(wp_reg) << F) + TOTAL - POS_W'(delay_rem);
    assign pos     = (pos_sum >= TOTAL) ? pos_sum - TOTAL : pos_sum;
    assign i1      = AW'(pos >> F);
    assign i2      = (i1 == LAST_IDX) ? '0 : i1 + 1'b1;

    // Shared multiplier
    always_comb begin
        case (state_reg)
            ST_MULI: begin
                mul_a = diff_reg;
                mul_b = WET_W'(frac_reg);
            end
            ST_MULF: begin
                mul_a = {delayed_reg[S-1], delayed_reg};
                mul_b = WET_W'(fb_reg);
            end
            ST_WRITE: begin
                mul_a = {delayed_reg[S-1], delayed_reg};
                mul_b = wet_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next   = mul_a * $signed({1'b0, mul_b});
    assign scaled_full = (prod_reg + ROUND_C) >>> GAIN_FRAC;
    assign mix_sum     = SUMW'(scaled_full) + {{2{x_reg[S-1]}}, x_reg};
    assign mix_sat     = (mix_sum > SAT_HI) ? S'(SAT_HI) :
                         (mix_sum < SAT_LO) ? S'(SAT_LO) : S'(mix_sum);
    assign s2          = v2_reg ? $signed(rd_data_reg) : '0;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        rd_addr    = i1_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = !rem_busy;
                if (s_tvalid && !rem_busy) begin
                    state_next = (wet_reg <= BYPASS_LIMIT) ? ST_DONE : ST_ADDR;
                end
            end
            ST_ADDR:  state_next = ST_RD1;
            ST_RD1:   state_next = ST_RD2;
            ST_RD2: begin
                rd_addr    = i2_reg;
                state_next = ST_DIFF;
            end
            ST_DIFF:  state_next = ST_MULI;
            ST_MULI:  state_next = ST_SUMI;
            ST_SUMI:  state_next = ST_MULF;
            ST_MULF:  state_next = ST_WRITE;
            ST_WRITE: begin
                mem_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Echo store, single port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store[wp_reg] <= mix_sat;
        end
        rd_data_reg <= store[rd_addr];
    end

    // Write pointer and fill tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
        end else if (mem_we) begin
            if (wp_reg == LAST_IDX) begin
                wp_reg   <= '0;
                full_reg <= 1'b1;
            end else begin
                wp_reg <= wp_reg + 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg      <= $signed(s_tdata[S-1:0]);
            bypass_reg <= (wet_reg <= BYPASS_LIMIT);
        end
        case (state_reg)
            ST_ADDR: begin
                i1_reg   <= i1;
                i2_reg   <= i2;
                frac_reg <= FRAC_W'(pos) & FRAC_MASK;
                // entries past the write pointer are unwritten since reset and read as zero
                v1_reg   <= full_reg || (i1 < wp_reg);
                v2_reg   <= full_reg || (i2 < wp_reg);
            end
            ST_RD2:   s1_reg <= v1_reg ? $signed(rd_data_reg) : '0;
            ST_DIFF:  diff_reg <= {s2[S-1], s2} - {s1_reg[S-1], s1_reg};
            ST_MULI:  prod_reg <= prod_next;
            ST_SUMI:  delayed_reg <= s1_reg + S'(prod_reg >>> F);
            ST_MULF:  prod_reg <= prod_next;
            ST_WRITE: prod_reg <= prod_next;
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= bypass_reg ? x_reg : mix_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_tdata_reg);

    // Pointer moves only on a store write
    a_wp_only_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !mem_we |=> $stable(wp_reg))
        else $error("write pointer moved without a store write");

    // A fresh result comes only from the final state
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final state");

    // Once the store has wrapped it stays fully written
    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |=> full_reg)
        else $error("fill flag dropped");

    // No echo item starts while the delay remainder is being worked out
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_busy |-> !(state_reg == ST_IDLE && state_next == ST_ADDR))
        else $error("item started while the delay was being reduced");

endmodule

>>> tb/feedback_delay_line_checker.sv
`timescale 1ns / 100ps
// Checker for the feedback delay line: tracks register writes, predicts each output sample.
module feedback_delay_line_checker
    import fdl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] sample_in
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,   // [15:0] sample_out
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending,
    output int                    echo_items,
    output int                    bypass_items
);
    localparam int ECHO_DEPTH = 131072;
    localparam int PRINT_CAP  = 50;

    logic signed [15:0] echo_mem [ECHO_DEPTH];
    logic [16:0]        wr_ptr;
    logic [DELAY_W-1:0] delay_q;
    logic [FB_W-1:0]    fb_gain;
    logic [WET_W-1:0]   wet_gain;
    logic [15:0]        expected_samples [$];
    int                 err_count = 0;
    int                 n_echo = 0;
    int                 n_bypass = 0;

    function automatic longint clip_sample(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Q1.16 gain (the feedback gain fits Q0.16), round half up
    function automatic longint apply_gain(input longint x, input longint g);
        return (x * g + 32768) >>> GAIN_FRAC;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("%0t checker: %s: expected %0d, got %0d", $time, what,
                     $signed(want), $signed(got));
    endtask

    task automatic predict_sample(input logic signed [15:0] dry);
        logic [DELAY_W-1:0] pos;
        logic [16:0]        i1;
        logic [16:0]        i2;
        longint             s1, s2, frac, delayed, x;
        x = dry;
        if (wet_gain <= BYPASS_LIMIT) begin
            expected_samples.push_back(dry);
            n_bypass++;
            return;
        end
        // read position wraps over the whole store in 1/256-sample units
        pos = {wr_ptr, 8'd0} - delay_q;
        i1 = pos[DELAY_W-1:8];
        i2 = i1 + 17'd1;
        frac = pos[7:0];
        s1 = echo_mem[i1];
        s2 = echo_mem[i2];
        delayed = (s1 * 256 + frac * (s2 - s1)) >>> 8;
        echo_mem[wr_ptr] = 16'(clip_sample(x + apply_gain(delayed, fb_gain)));
        wr_ptr = wr_ptr + 17'd1;
        expected_samples.push_back(16'(clip_sample(x + apply_gain(delayed, wet_gain))));
        n_echo++;
    endtask

    always @(posedge aclk) begin
        logic [15:0] want;
        if (!aresetn) begin
            foreach (echo_mem[k]) echo_mem[k] = '0;
            wr_ptr = '0;
            delay_q = DELAY_RESET;
            fb_gain = '0;
            wet_gain = '0;
            expected_samples.delete();
        end else begin
            // retire the output first: an item taken at this edge cannot have its result yet
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("sample_out with nothing pending", 'x, m_tdata);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want) report_mismatch("sample_out", want, m_tdata);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_DELAY: delay_q = cfg_data[DELAY_W-1:0];
                    REG_FEEDBACK: begin
                        fb_gain = (cfg_data[FB_W-1:0] > FEEDBACK_MAX) ? FEEDBACK_MAX
                                                                       : cfg_data[FB_W-1:0];
                    end
                    REG_WET: begin
                        wet_gain = (cfg_data[WET_W-1:0] > WET_ONE) ? WET_ONE
                                                                    : cfg_data[WET_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_sample(s_tdata);
        end
        pending      <= expected_samples.size();
        mismatches   <= err_count;
        echo_items   <= n_echo;
        bypass_items <= n_bypass;
    end

endmodule

>>> tb/feedback_delay_line_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the feedback delay line: clock, reset, stimulus, flow control, verdict.
module feedback_delay_line_unit_tb
    import fdl_pkg::*;
();

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 400;
    localparam int IDLE_LIMIT      = 5000;
    localparam int PHASES          = 12;
    localparam int PHASE_ITEMS     = 150;
    localparam int SETTLE_CYCLES   = 20;

    // index past the register list; writes to it must do nothing
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;    // [15:0] sample_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [15:0] sample_out
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int       mismatches, pending, echo_items, bypass_items;
    int       samples_sent = 0;
    int       burst_left = 1;
    int       idle_cycles = 0;
    int       hold_left = 0;
    int       config_sets = 0;
    bit       hold_done = 1'b0;
    rx_mode_t rx_mode = RX_FREE;

    feedback_delay_line_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    feedback_delay_line_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending),
        .echo_items  (echo_items),
        .bypass_items(bypass_items)
    );

    always #5 aclk = ~aclk;

    // Output side: one long hold-off to back up the block, otherwise a drifting stall pattern.
    always @(posedge aclk) begin
        if (!hold_done && samples_sent >= HOLD_OFF_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(63, 0) == 0) rx_mode <= rx_mode_t'($urandom_range(2, 0));
            case (rx_mode)
                RX_FREE:  m_tready <= 1'b1;
                RX_LIGHT: m_tready <= ($urandom_range(3, 0) != 0);
                default:  m_tready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("feedback_delay_line_unit_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item and hold it until taken; at the end of a burst, usually leave a random gap.
    task automatic send_sample(input logic [15:0] v);
        s_tdata <= v;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(24, 1);
            if ($urandom_range(3, 0) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_echo(input logic [CFG_DATA_W-1:0] delay,
                            input logic [CFG_DATA_W-1:0] fb,
                            input logic [CFG_DATA_W-1:0] wet);
        write_reg(REG_DELAY, delay);
        write_reg(REG_FEEDBACK, fb);
        write_reg(REG_WET, wet);
        config_sets++;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9, 0))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(511, 0) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_delay();
        case ($urandom_range(9, 0))
            0, 1, 2, 3, 4, 5: return CFG_DATA_W'($urandom_range(64 * 256, 256));
            6:       return CFG_DATA_W'($urandom_range(255, 0));
            7:       return CFG_DATA_W'($urandom);
            8:       return CFG_DATA_W'(33554176 - $urandom_range(4096, 0));
            default: return CFG_DATA_W'($urandom_range(2048 * 256, 256));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_feedback();
        case ($urandom_range(5, 0))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(65535, 62000));
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(62259, 0));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_wet();
        case ($urandom_range(7, 0))
            0:       return CFG_DATA_W'($urandom_range(65, 0));
            1:       return CFG_DATA_W'(WET_ONE);
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(65536, 66));
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings bypass the echo: extremes pass through untouched
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        drain_results();

        // wet gain right at the bypass limit
        write_reg(REG_WET, CFG_DATA_W'(BYPASS_LIMIT));
        send_sample(16'h1234);
        send_sample(16'h8000);
        drain_results();

        // one-sample delay, full feedback and wet gain: saturate both sums
        set_echo(25'd256, CFG_DATA_W'(FEEDBACK_MAX), CFG_DATA_W'(WET_ONE));
        repeat (4) send_sample(16'h7FFF);
        repeat (3) send_sample(16'h8000);
        drain_results();

        // zero delay reads the entry about to be overwritten; wet just above bypass
        write_reg(REG_DELAY, '0);
        write_reg(REG_WET, CFG_DATA_W'(BYPASS_LIMIT + 1'b1));
        send_sample(16'h7FFF);
        send_sample(16'hC000);
        send_sample(16'h0100);
        drain_results();

        // half-sample delay, out-of-range gains clamp, junk above register widths ignored
        set_echo(25'd128, '1, '1);
        write_reg(REG_NONE, '1);
        send_sample(16'h4000);
        send_sample(16'hC000);
        send_sample(16'h7FFF);
        send_sample(16'h0100);
        drain_results();

        // largest delay field wraps around the store
        write_reg(REG_DELAY, '1);
        send_sample(16'h2000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            set_echo(pick_delay(), pick_feedback(), pick_wet());
            if ($urandom_range(3, 0) == 0) write_reg(REG_NONE, CFG_DATA_W'($urandom));
            repeat (PHASE_ITEMS) send_sample(pick_sample());
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d samples: %0d through the echo path, %0d bypassed, %0d settings",
                 samples_sent, echo_items, bypass_items, config_sets);
        $display("output held off once for %0d cycles with input still offered",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("feedback_delay_line_unit_tb: PASS");
        end else begin
            $display("feedback_delay_line_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
